[design/tofp_pkg.sv]
// ----------------------------------------------------------------------------
// tofp_pkg: shared types and constants for the tensor op fusion peephole
// Instruction and result layouts, config register indexes and reset codes.
// ----------------------------------------------------------------------------
package tofp_pkg;

  localparam int unsigned CodeW     = 5;
  localparam int unsigned RegW      = 4;
  localparam int unsigned ImmW      = 32;
  localparam int unsigned ShapeW    = 16;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned PtrW      = $clog2(FifoDepth);
  localparam int unsigned CntW      = PtrW + 1;

  localparam logic [CodeW-1:0] MatmulCodeRst = 5'd0;
  localparam logic [CodeW-1:0] AddCodeRst    = 5'd1;
  localparam logic [CodeW-1:0] ReluCodeRst   = 5'd2;

  localparam logic [ImmW-1:0] ReluFuseBit = 32'h8000_0000;
  localparam logic [ImmW-1:0] AddFuseBit  = 32'h4000_0000;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MATMUL = 2'd0,
    CFG_ADD    = 2'd1,
    CFG_RELU   = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [CodeW-1:0] matmul_code;
    logic [CodeW-1:0] add_code;
    logic [CodeW-1:0] relu_code;
  } cfg_t;

  typedef struct packed {
    logic [CodeW-1:0]  op;
    logic [RegW-1:0]   dst;
    logic [RegW-1:0]   src_first;
    logic [RegW-1:0]   src_second;
    logic [ImmW-1:0]   imm;
    logic [ShapeW-1:0] shape_a_rows;
    logic [ShapeW-1:0] shape_a_cols;
    logic [ShapeW-1:0] shape_b_rows;
    logic [ShapeW-1:0] shape_b_cols;
    logic              in_last;
  } in_item_t;

  typedef struct packed {
    logic [CodeW-1:0]  out_op;
    logic [RegW-1:0]   out_dst;
    logic [RegW-1:0]   out_src_first;
    logic [RegW-1:0]   out_src_second;
    logic [ImmW-1:0]   out_imm;
    logic [ShapeW-1:0] out_shape_a_rows;
    logic [ShapeW-1:0] out_shape_a_cols;
    logic [ShapeW-1:0] out_shape_b_rows;
    logic [ShapeW-1:0] out_shape_b_cols;
    logic              out_last;
  } out_item_t;

  typedef struct packed {
    logic first;
    logic second;
  } push_t;

  function automatic out_item_t to_out(in_item_t it, logic [ImmW-1:0] fuse, logic last);
    out_item_t o;
    o.out_op           = it.op;
    o.out_dst          = it.dst;
    o.out_src_first    = it.src_first;
    o.out_src_second   = it.src_second;
    o.out_imm          = it.imm | fuse;
    o.out_shape_a_rows = it.shape_a_rows;
    o.out_shape_a_cols = it.shape_a_cols;
    o.out_shape_b_rows = it.shape_b_rows;
    o.out_shape_b_cols = it.shape_b_cols;
    o.out_last         = last;
    return o;
  endfunction

endpackage

[design/tofp_core.sv]
// ----------------------------------------------------------------------------
// tofp_core: pending instruction register and fusion decision
// Compares the held instruction with the incoming one and produces up to two
// results per transfer.
// ----------------------------------------------------------------------------
module tofp_core import tofp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      accept_i,
  input  in_item_t  item_i,
  output push_t     push_o,
  output out_item_t res_first_o,
  output out_item_t res_second_o
);

  logic            held_valid_q, held_valid_d;
  in_item_t        held_q;
  logic            reads;
  logic            held_mm, held_add, in_relu, in_add;
  logic [ImmW-1:0] fuse;
  logic            fused;

  assign reads    = item_i.src_first == held_q.dst;
  assign held_mm  = held_q.op == cfg_i.matmul_code;
  assign held_add = held_q.op == cfg_i.add_code;
  assign in_relu  = item_i.op == cfg_i.relu_code;
  assign in_add   = item_i.op == cfg_i.add_code;

  always_comb begin
    fuse = '0;
    if (held_mm && in_relu && reads) begin
      fuse = ReluFuseBit;
    end else if (held_add && in_relu && reads) begin
      fuse = ReluFuseBit;
    end else if (held_mm && in_add && reads) begin
      fuse = AddFuseBit;
    end
  end

  assign fused = fuse != '0;

  always_comb begin
    push_o       = '0;
    held_valid_d = held_valid_q;
    res_first_o  = to_out(held_q, fuse, 1'b0);
    res_second_o = to_out(item_i, '0, 1'b1);
    if (accept_i) begin
      if (!held_valid_q) begin
        if (item_i.in_last) begin
          push_o.first = 1'b1;
          res_first_o  = to_out(item_i, '0, 1'b1);
        end else begin
          held_valid_d = 1'b1;
        end
      end else if (fused) begin
        push_o.first       = 1'b1;
        res_first_o        = to_out(held_q, fuse, item_i.in_last);
        held_valid_d       = 1'b0;
      end else begin
        push_o.first = 1'b1;
        if (item_i.in_last) begin
          push_o.second = 1'b1;
          held_valid_d  = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_valid_q <= 1'b0;
    end else begin
      held_valid_q <= held_valid_d;
    end
  end

  // hold the incoming instruction whenever it becomes the pending one
  always_ff @(posedge clk_i) begin
    if (accept_i && held_valid_d && !fused) begin
      held_q <= item_i;
    end else if (accept_i && !held_valid_q) begin
      held_q <= item_i;
    end
  end

endmodule

[design/tofp_fifo.sv]
// ----------------------------------------------------------------------------
// tofp_fifo: result queue
// Four-entry queue that takes one or two results per cycle and offers one.
// ----------------------------------------------------------------------------
module tofp_fifo import tofp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  push_t     push_i,
  input  out_item_t wr_first_i,
  input  out_item_t wr_second_i,
  output logic      space_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  out_item_t       mem_q [FifoDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic [PtrW-1:0] wr_next;
  logic            pop;

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = count_q != '0;
  assign out_item_o  = mem_q[rd_ptr_q];
  assign space_o     = count_q <= CntW'(FifoDepth - 2);
  assign wr_next     = wr_ptr_q + PtrW'(1);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    count_d  = count_q;
    rd_ptr_d = rd_ptr_q;
    if (push_i.first && push_i.second) begin
      wr_ptr_d = wr_ptr_q + PtrW'(2);
      count_d  = count_q + CntW'(2);
    end else if (push_i.first) begin
      wr_ptr_d = wr_next;
      count_d  = count_q + CntW'(1);
    end
    if (pop) begin
      rd_ptr_d = rd_ptr_q + PtrW'(1);
      count_d  = count_d - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.first) begin
      mem_q[wr_ptr_q] <= wr_first_i;
    end
    if (push_i.second) begin
      mem_q[wr_next] <= wr_second_i;
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(FifoDepth))
    else $error("result queue count out of range");

  a_second_needs_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.second |-> push_i.first)
    else $error("second result pushed without first");

  a_push_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.first |-> count_q <= CntW'(FifoDepth - 2))
    else $error("push into result queue without room");

  a_pop_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !push_i.first) |=> count_q == $past(count_q) - CntW'(1))
    else $error("pop did not drain result queue");
`endif

endmodule

[design/tensor_op_fusion_peephole_top.sv]
// ----------------------------------------------------------------------------
// tensor_op_fusion_peephole_top: tensor instruction fusion peephole
// One-instruction lookahead that folds ReLU and add into the preceding op.
// ----------------------------------------------------------------------------
// Usage:
//   Instructions enter on in_valid_i/in_ready_o as in_item_i; results leave
//   on out_valid_o/out_ready_i as out_item_o. Each instruction is held until
//   the next one arrives, so a result is queued on the transfer of
//   the instruction that decides it (a fusion or a plain pass), and a program
//   end (in_last set) flushes the pending instruction.
//   Throughput is one instruction per cycle while the queue has room, also
//   across flushes that yield two results. Results sit in a four-entry queue;
//   in_ready_o is high while at least two entries are free, so a stalled
//   receiver fills the queue and then holds off the sender.
//   Opcode codes are written on cfg_we_i/cfg_idx_i/cfg_wdata_i while idle.
//   Reset empties the queue, drops the pending instruction and restores the
//   default opcode codes (matmul 0, add 1, ReLU 2).
// ----------------------------------------------------------------------------
module tensor_op_fusion_peephole_top import tofp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CodeW-1:0]   cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  in_item_t           in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output out_item_t          out_item_o
);

  cfg_t      cfg_q;
  logic      accept;
  push_t     push;
  out_item_t res_first, res_second;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.matmul_code <= MatmulCodeRst;
      cfg_q.add_code    <= AddCodeRst;
      cfg_q.relu_code   <= ReluCodeRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_MATMUL: cfg_q.matmul_code <= cfg_wdata_i;
        CFG_ADD:    cfg_q.add_code    <= cfg_wdata_i;
        CFG_RELU:   cfg_q.relu_code   <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  assign accept = in_valid_i && in_ready_o;

  tofp_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .accept_i     (accept),
    .item_i       (in_item_i),
    .push_o       (push),
    .res_first_o  (res_first),
    .res_second_o (res_second)
  );

  tofp_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .wr_first_i  (res_first),
    .wr_second_i (res_second),
    .space_o     (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

[test/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: testbench for the tensor op fusion peephole
// Drives instruction programs through the valid/ready input and checks every
// emitted instruction against a directed table or a lookahead predictor that
// runs on each input transfer. Opcode codes change between phases, while the
// block is idle. Phases vary the sender gaps and receiver stalls, and one
// phase holds off the receiver long enough to back up the result queue.
// ----------------------------------------------------------------------------
module tb_top;
  import tofp_pkg::*;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CodeW-1:0]   cfg_wdata_i;
  logic               in_valid_i;
  logic               in_ready_o;
  in_item_t           in_item_i;
  logic               out_valid_o;
  logic               out_ready_i;
  out_item_t          out_item_o;

  tensor_op_fusion_peephole_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  logic [CodeW-1:0] code_matmul;
  logic [CodeW-1:0] code_add;
  logic [CodeW-1:0] code_relu;
  logic             look_valid;
  in_item_t         look;
  out_item_t        step_emits[$];
  out_item_t        want_emits[$];

  int fail_count;
  int send_gap_pct;
  int stall_pct;
  bit hold_req;

  in_item_t  dir_in[$];
  int        dir_n[$];
  out_item_t dir_r0[$];
  out_item_t dir_r1[$];

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  function automatic out_item_t emit_of(in_item_t it, logic [ImmW-1:0] fuse, logic last);
    out_item_t o;
    o.out_op           = it.op;
    o.out_dst          = it.dst;
    o.out_src_first    = it.src_first;
    o.out_src_second   = it.src_second;
    o.out_imm          = it.imm | fuse;
    o.out_shape_a_rows = it.shape_a_rows;
    o.out_shape_a_cols = it.shape_a_cols;
    o.out_shape_b_rows = it.shape_b_rows;
    o.out_shape_b_cols = it.shape_b_cols;
    o.out_last         = last;
    return o;
  endfunction

  // one-instruction lookahead: hold, fuse into the held op, or pass it on
  function automatic void peephole_step(in_item_t it);
    logic [ImmW-1:0] fuse;
    step_emits.delete();
    if (!look_valid) begin
      if (it.in_last) begin
        step_emits.push_back(emit_of(it, '0, 1'b1));
      end else begin
        look_valid = 1'b1;
        look       = it;
      end
      return;
    end
    fuse = '0;
    if (it.src_first == look.dst) begin
      if (look.op == code_matmul && it.op == code_relu) fuse = ReluFuseBit;
      else if (look.op == code_add && it.op == code_relu) fuse = ReluFuseBit;
      else if (look.op == code_matmul && it.op == code_add) fuse = AddFuseBit;
    end
    if (fuse != '0) begin
      step_emits.push_back(emit_of(look, fuse, it.in_last));
      look_valid = 1'b0;
    end else begin
      step_emits.push_back(emit_of(look, '0, 1'b0));
      if (it.in_last) begin
        step_emits.push_back(emit_of(it, '0, 1'b1));
        look_valid = 1'b0;
      end else begin
        look = it;
      end
    end
  endfunction

  function automatic in_item_t mk(logic [CodeW-1:0] op, logic [RegW-1:0] dst,
                                  logic [RegW-1:0] s1, logic [RegW-1:0] s2,
                                  logic [ImmW-1:0] imm, logic [ShapeW-1:0] ar,
                                  logic [ShapeW-1:0] ac, logic [ShapeW-1:0] br,
                                  logic [ShapeW-1:0] bc, logic last);
    in_item_t it;
    it.op           = op;
    it.dst          = dst;
    it.src_first    = s1;
    it.src_second   = s2;
    it.imm          = imm;
    it.shape_a_rows = ar;
    it.shape_a_cols = ac;
    it.shape_b_rows = br;
    it.shape_b_cols = bc;
    it.in_last      = last;
    return it;
  endfunction

  function automatic logic [ShapeW-1:0] rand_shape();
    int pick;
    pick = $urandom_range(9);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return ShapeW'($urandom_range(65535));
  endfunction

  function automatic in_item_t rand_instr(logic [RegW-1:0] prev_dst, logic last);
    in_item_t it;
    int pick;
    pick = $urandom_range(9);
    case (pick)
      0, 1, 2: it.op = code_matmul;
      3, 4:    it.op = code_add;
      5, 6, 7: it.op = code_relu;
      default: it.op = CodeW'($urandom_range(31));
    endcase
    it.dst          = RegW'($urandom_range(15));
    it.src_first    = ($urandom_range(9) < 6) ? prev_dst : RegW'($urandom_range(15));
    it.src_second   = RegW'($urandom_range(15));
    it.imm          = $urandom;
    it.shape_a_rows = rand_shape();
    it.shape_a_cols = rand_shape();
    it.shape_b_rows = rand_shape();
    it.shape_b_cols = rand_shape();
    it.in_last      = last;
    return it;
  endfunction

  task automatic add_row(in_item_t it, int n, out_item_t r0, out_item_t r1);
    dir_in.push_back(it);
    dir_n.push_back(n);
    dir_r0.push_back(r0);
    dir_r1.push_back(r1);
  endtask

  // n < 0: expectations come from the predictor
  task automatic send_instr(in_item_t it, int n, out_item_t r0, out_item_t r1);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    peephole_step(it);
    if (n < 0) begin
      foreach (step_emits[k]) want_emits.push_back(step_emits[k]);
    end else begin
      if (n > 0) want_emits.push_back(r0);
      if (n > 1) want_emits.push_back(r1);
    end
    @(negedge clk_i);
  endtask

  task automatic write_code(cfg_idx_e idx, logic [CodeW-1:0] v);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= v;
    case (idx)
      CFG_MATMUL: code_matmul = v;
      CFG_ADD:    code_add    = v;
      default:    code_relu   = v;
    endcase
    @(negedge clk_i);
  endtask

  task automatic set_codes(logic [CodeW-1:0] m, logic [CodeW-1:0] a, logic [CodeW-1:0] r);
    write_code(CFG_MATMUL, m);
    write_code(CFG_ADD, a);
    write_code(CFG_RELU, r);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (want_emits.size() != 0) @(negedge clk_i);
    repeat (6) @(negedge clk_i);
  endtask

  task automatic run_programs(int n_items);
    in_item_t        it;
    logic [RegW-1:0] prev_dst;
    int              left;
    prev_dst = '0;
    left     = 0;
    for (int k = 0; k < n_items; k++) begin
      if (left == 0) left = $urandom_range(8, 1);
      left--;
      it = rand_instr(prev_dst, (left == 0) || (k == n_items - 1));
      prev_dst = it.dst;
      send_instr(it, -1, '0, '0);
    end
  endtask

  task automatic check_field(string name, logic [ImmW-1:0] want, logic [ImmW-1:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk_i) begin : check_emits
    out_item_t w;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (want_emits.size() == 0) begin
        $error("unexpected transfer: op 0x%0h imm 0x%0h", out_item_o.out_op, out_item_o.out_imm);
        fail_count++;
      end else begin
        w = want_emits.pop_front();
        check_field("out_op", ImmW'(w.out_op), ImmW'(out_item_o.out_op));
        check_field("out_dst", ImmW'(w.out_dst), ImmW'(out_item_o.out_dst));
        check_field("out_src_first", ImmW'(w.out_src_first),
                    ImmW'(out_item_o.out_src_first));
        check_field("out_src_second", ImmW'(w.out_src_second),
                    ImmW'(out_item_o.out_src_second));
        check_field("out_imm", w.out_imm, out_item_o.out_imm);
        check_field("out_shape_a_rows", ImmW'(w.out_shape_a_rows),
                    ImmW'(out_item_o.out_shape_a_rows));
        check_field("out_shape_a_cols", ImmW'(w.out_shape_a_cols),
                    ImmW'(out_item_o.out_shape_a_cols));
        check_field("out_shape_b_rows", ImmW'(w.out_shape_b_rows),
                    ImmW'(out_item_o.out_shape_b_rows));
        check_field("out_shape_b_cols", ImmW'(w.out_shape_b_cols),
                    ImmW'(out_item_o.out_shape_b_cols));
        check_field("out_last", ImmW'(w.out_last), ImmW'(out_item_o.out_last));
      end
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin : receiver
    bit hold_done;
    out_ready_i = 1'b0;
    hold_done   = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req && !hold_done) begin
        out_ready_i <= 1'b0;
        repeat (80) @(negedge clk_i);
        hold_done = 1'b1;
      end else begin
        out_ready_i <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  initial begin
    #800000;
    $display("simulation failed");
    $finish;
  end

  initial begin : stimulus
    in_item_t a;
    in_item_t b;
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = CFG_MATMUL;
    cfg_wdata_i  = '0;
    in_valid_i   = 1'b0;
    in_item_i    = '0;
    fail_count   = 0;
    send_gap_pct = 0;
    stall_pct    = 0;
    hold_req     = 1'b0;
    look_valid   = 1'b0;
    look         = '0;
    code_matmul  = MatmulCodeRst;
    code_add     = AddCodeRst;
    code_relu    = ReluCodeRst;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    a = mk(5'd31, 4'hf, 4'hf, 4'hf, '1, '1, '1, '1, '1, 1'b1);
    add_row(a, 1, emit_of(a, '0, 1'b1), '0);
    a = mk(MatmulCodeRst, 4'h0, 4'h0, 4'h0, '0, '0, '0, '0, '0, 1'b1);
    add_row(a, 1, emit_of(a, '0, 1'b1), '0);
    a = mk(MatmulCodeRst, 4'h3, 4'h1, 4'h2, '0, 16'd1, 16'd2, 16'd3, 16'd4, 1'b0);
    add_row(a, 0, '0, '0);
    b = mk(ReluCodeRst, 4'h9, 4'h3, 4'h6, 32'hdead_beef, '1, '0, '1, '0, 1'b0);
    add_row(b, 1, emit_of(a, ReluFuseBit, 1'b0), '0);
    a = mk(AddCodeRst, 4'h5, 4'h0, 4'hf, 32'h1234_5678, '1, '0, '1, '0, 1'b0);
    add_row(a, 0, '0, '0);
    b = mk(ReluCodeRst, 4'h0, 4'h5, 4'h0, '0, '0, '0, '0, '0, 1'b1);
    add_row(b, 1, emit_of(a, ReluFuseBit, 1'b1), '0);
    a = mk(MatmulCodeRst, 4'h7, 4'h2, 4'h2, 32'h4000_0001, 16'h8000, 16'h7fff, 16'h1, 16'h0, 1'b0);
    add_row(a, 0, '0, '0);
    b = mk(AddCodeRst, 4'h8, 4'h7, 4'h1, 32'h5555_5555, '0, '1, '0, '1, 1'b0);
    add_row(b, 1, emit_of(a, AddFuseBit, 1'b0), '0);
    a = mk(MatmulCodeRst, 4'h2, 4'h0, 4'h0, 32'h8000_0000, 16'd7, 16'd7, 16'd7, 16'd7, 1'b0);
    add_row(a, 0, '0, '0);
    b = mk(ReluCodeRst, 4'h4, 4'h3, 4'h0, 32'haaaa_aaaa, 16'd5, 16'd6, 16'd7, 16'd8, 1'b0);
    add_row(b, 1, emit_of(a, '0, 1'b0), '0);
    a = mk(5'd9, 4'h1, 4'h4, 4'h4, 32'h0f0f_0f0f, 16'h1234, 16'h5678, 16'h9abc, 16'hdef0, 1'b1);
    add_row(a, 2, emit_of(b, '0, 1'b0), emit_of(a, '0, 1'b1));
    add_row(mk(AddCodeRst, 4'h4, 4'h1, 4'h2, 32'h0000_0010, 16'd3, 16'd3, 16'd3, 16'd3, 1'b0),
            -1, '0, '0);
    add_row(mk(AddCodeRst, 4'h6, 4'h4, 4'h4, 32'hc000_0000, 16'd9, 16'd9, 16'd9, 16'd9, 1'b0),
            -1, '0, '0);
    add_row(mk(ReluCodeRst, 4'h6, 4'h6, 4'h0, '1, '1, '1, '1, '1, 1'b0), -1, '0, '0);
    add_row(mk(MatmulCodeRst, 4'h1, 4'h5, 4'ha, '0, 16'd64, 16'd32, 16'd32, 16'd16, 1'b0),
            -1, '0, '0);
    add_row(mk(AddCodeRst, 4'hb, 4'h1, 4'hc, '1, '0, '0, '0, '0, 1'b0), -1, '0, '0);
    add_row(mk(MatmulCodeRst, 4'hf, 4'he, 4'hd, 32'h8000_0000, '1, '0, '0, '1, 1'b0),
            -1, '0, '0);
    add_row(mk(ReluCodeRst, 4'h2, 4'hf, 4'h3, 32'h0000_0001, '0, '1, '1, '0, 1'b0), -1, '0, '0);
    add_row(mk(MatmulCodeRst, 4'h0, 4'h3, 4'h3, 32'h7fff_ffff, 16'd2, 16'd2, 16'd2, 16'd2, 1'b0),
            -1, '0, '0);
    add_row(mk(MatmulCodeRst, 4'h3, 4'h0, 4'h3, 32'h1, 16'd1, 16'd1, 16'd1, 16'd1, 1'b0),
            -1, '0, '0);
    add_row(mk(ReluCodeRst, 4'h5, 4'h7, 4'h5, 32'h2, 16'd4, 16'd4, 16'd4, 16'd4, 1'b0),
            -1, '0, '0);
    add_row(mk(ReluCodeRst, 4'h8, 4'h5, 4'h8, 32'h3, 16'd8, 16'd8, 16'd8, 16'd8, 1'b1),
            -1, '0, '0);
    foreach (dir_in[k]) send_instr(dir_in[k], dir_n[k], dir_r0[k], dir_r1[k]);
    drain();

    set_codes(5'd31, 5'd0, 5'd15);
    send_gap_pct = 0;
    stall_pct    = 0;
    hold_req     = 1'b1;
    run_programs(110);
    drain();

    set_codes(5'd5, 5'd5, 5'd5);
    send_gap_pct = 48;
    stall_pct    = 0;
    run_programs(100);
    drain();

    set_codes(5'd0, 5'd31, 5'd31);
    send_gap_pct = 0;
    stall_pct    = 48;
    run_programs(110);
    drain();

    set_codes(5'd31, 5'd30, 5'd0);
    send_gap_pct = 14;
    stall_pct    = 14;
    run_programs(110);
    drain();

    set_codes(CodeW'($urandom_range(31)), CodeW'($urandom_range(31)),
              CodeW'($urandom_range(31)));
    send_gap_pct = 0;
    stall_pct    = 0;
    run_programs(100);
    drain();

    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
